FILE: rtl/core/qte_pkg.sv
`default_nettype none
package qte_pkg;

  localparam int unsigned CORDIC_ITERATIONS = 16;
  localparam int unsigned AtanLen = 24;
  localparam int unsigned CordicN =
      (CORDIC_ITERATIONS > AtanLen) ? AtanLen : CORDIC_ITERATIONS;
  // pre-rotation + micro-rotations + product + rounding
  localparam int unsigned CordicLat = CordicN + 3;
  localparam int unsigned SqrtStages = 32;
  localparam int unsigned DataW = 37;
  localparam int unsigned AngW = 34;
  localparam int unsigned MagW = 17;

  localparam logic [AngW-1:0] QuarterTurn = AngW'(64'd1073741824);
  localparam logic [30:0] PiQ29 = 31'd1686629713;
  localparam logic [MagW-1:0] PiQ13 = MagW'(25736);
  localparam logic [MagW-1:0] HalfPiQ13 = MagW'(12868);

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
  } qte_vec_t;

  typedef struct packed {
    logic neg;
    logic [MagW-1:0] mag;
  } qte_angle_t;

  typedef struct packed {
    logic zero;
    logic gimbal;
    logic p_pos;
  } qte_side_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [31:0] atan_units(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/qte_cordic.sv
`default_nettype none
module qte_cordic (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire qte_pkg::qte_vec_t vec_i,
  output qte_pkg::qte_angle_t    angle_o
);
  import qte_pkg::*;

  logic signed [DataW-1:0] x_q [0:CordicN];
  logic signed [DataW-1:0] y_q [0:CordicN];
  logic signed [AngW-1:0]  z_q [0:CordicN];
  logic                    zero_q [0:CordicN];

  logic signed [DataW-1:0] x0_d, y0_d;
  logic signed [AngW-1:0]  z0_d;

  // pre-rotate a negative x by a quarter turn
  always_comb begin
    x0_d = vec_i.x;
    y0_d = vec_i.y;
    z0_d = '0;
    if (vec_i.x < 0) begin
      if (vec_i.y >= 0) begin
        x0_d = vec_i.y;
        y0_d = -vec_i.x;
        z0_d = QuarterTurn;
      end else begin
        x0_d = -vec_i.y;
        y0_d = vec_i.x;
        z0_d = -QuarterTurn;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0_d;
      y_q[0]    <= y0_d;
      z_q[0]    <= z0_d;
      zero_q[0] <= (vec_i.x == 0) && (vec_i.y == 0);
    end
  end

  for (genvar i = 0; i < CordicN; i++) begin : g_rot
    logic signed [DataW-1:0] xs, ys;
    logic signed [AngW-1:0]  a;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign a  = AngW'(atan_units(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + a;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - a;
        end
      end
    end
  end

  // angle units to Q3.13: mag * round(pi * 2^29) / 2^47, split in two halves
  logic signed [AngW-1:0] zf;
  logic [AngW-1:0]        zmag;
  logic [46:0]            hi_q, lo_q;
  logic                   neg_q, zero_m_q;
  logic [63:0]            sum;
  logic [MagW-1:0]        mag_q;
  logic                   neg_r_q;

  assign zf   = z_q[CordicN];
  assign zmag = (zf < 0) ? AngW'(-zf) : AngW'(zf);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q     <= zmag[31:16] * PiQ29;
      lo_q     <= zmag[15:0] * PiQ29;
      neg_q    <= zf < 0;
      zero_m_q <= zero_q[CordicN];
    end
  end

  assign sum = {1'b0, hi_q, 16'b0} + {17'b0, lo_q} + (64'd1 << 46);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= zero_m_q ? '0 : sum[63:47];
      neg_r_q <= neg_q && !zero_m_q;
    end
  end

  assign angle_o.neg = neg_r_q;
  assign angle_o.mag = mag_q;

endmodule
`default_nettype wire

FILE: rtl/core/quaternion_to_euler_angles.sv
// Throughput: one quaternion per cycle; the fixed-depth pipeline (products,
// 32 square-root stages, one CORDIC stage per micro-rotation) advances as a
// whole whenever the output register is empty or taken.
// Reset: asynchronous active low, clears the valid bits; data is not reset.
`default_nettype none
module quaternion_to_euler_angles (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // roll_angle, pitch_angle, yaw_angle, pad
  output logic             m_axis_tuser   // zero_norm
);
  import qte_pkg::*;

  localparam int unsigned Lat = 3 + SqrtStages + CordicLat + 1;
  localparam int unsigned SideLen = SqrtStages + CordicLat;

  logic en;
  logic valid_q [0:Lat-1];

  assign en            = !valid_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Lat; k++) valid_q[k] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= s_axis_tvalid;
      for (int k = 1; k < Lat; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  // stage 1: products
  logic signed [15:0] w, x, y, z;
  assign w = s_axis_tdata[15:0];
  assign x = s_axis_tdata[31:16];
  assign y = s_axis_tdata[47:32];
  assign z = s_axis_tdata[63:48];

  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, wx_q, yz_q, wz_q, xy_q, wy_q, zx_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= w * w;  xx_q <= x * x;  yy_q <= y * y;  zz_q <= z * z;
      wx_q <= w * x;  yz_q <= y * z;  wz_q <= w * z;  xy_q <= x * y;
      wy_q <= w * y;  zx_q <= z * x;
    end
  end

  // stage 2: norm and atan2 operands
  logic signed [DataW-1:0] s_d, p_d;
  qte_vec_t roll2_q, yaw2_q;
  logic signed [DataW-1:0] s2_q, p2_q;
  assign s_d = DataW'(ww_q) + DataW'(xx_q) + DataW'(yy_q) + DataW'(zz_q);
  assign p_d = (DataW'(wy_q) - DataW'(zx_q)) <<< 1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll2_q.y <= (DataW'(wx_q) + DataW'(yz_q)) <<< 1;
      roll2_q.x <= s_d - ((DataW'(xx_q) + DataW'(yy_q)) <<< 1);
      yaw2_q.y  <= (DataW'(wz_q) + DataW'(xy_q)) <<< 1;
      yaw2_q.x  <= s_d - ((DataW'(yy_q) + DataW'(zz_q)) <<< 1);
      s2_q      <= s_d;
      p2_q      <= p_d;
    end
  end

  // stage 3: gimbal test and square-root operand (s^2 - P^2) / 16
  logic [DataW-1:0] pmag;
  logic [30:0]      sp, pp;
  logic [31:0]      spp;
  logic [30:0]      smp;
  assign pmag = (p2_q < 0) ? DataW'(-p2_q) : DataW'(p2_q);
  assign sp   = s2_q[32:2];
  assign pp   = pmag[32:2];
  assign smp  = sp - pp;
  assign spp  = {1'b0, sp} + {1'b0, pp};

  logic [63:0] rem_q [0:SqrtStages];
  logic [63:0] res_q [0:SqrtStages];
  qte_vec_t    roll_q [0:SqrtStages];
  qte_vec_t    yaw_q  [0:SqrtStages];
  logic signed [DataW-1:0] py_q [0:SqrtStages];
  qte_side_t   side_q [0:SideLen];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]  <= 64'(smp) * 64'(spp);
      res_q[0]  <= '0;
      roll_q[0] <= roll2_q;
      yaw_q[0]  <= yaw2_q;
      py_q[0]   <= (p2_q < 0) ? -DataW'({1'b0, pp}) : DataW'({1'b0, pp});
      side_q[0].zero   <= s2_q == 0;
      side_q[0].gimbal <= pmag >= DataW'(s2_q);
      side_q[0].p_pos  <= p2_q > 0;
    end
  end

  // bitwise square root, one result bit per stage
  for (genvar k = 0; k < SqrtStages; k++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = res_q[k] + Bit;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (rem_q[k] >= trial) begin
          rem_q[k+1] <= rem_q[k] - trial;
          res_q[k+1] <= (res_q[k] >> 1) + Bit;
        end else begin
          rem_q[k+1] <= rem_q[k];
          res_q[k+1] <= res_q[k] >> 1;
        end
        roll_q[k+1] <= roll_q[k];
        yaw_q[k+1]  <= yaw_q[k];
        py_q[k+1]   <= py_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 1; k <= SideLen; k++) side_q[k] <= side_q[k-1];
    end
  end

  qte_vec_t   pitch_vec;
  qte_angle_t roll_a, pitch_a, yaw_a;
  assign pitch_vec.x = DataW'(res_q[SqrtStages]);
  assign pitch_vec.y = py_q[SqrtStages];

  qte_cordic u_roll (
    .clk_i, .en_i(en), .vec_i(roll_q[SqrtStages]), .angle_o(roll_a)
  );
  qte_cordic u_pitch (
    .clk_i, .en_i(en), .vec_i(pitch_vec), .angle_o(pitch_a)
  );
  qte_cordic u_yaw (
    .clk_i, .en_i(en), .vec_i(yaw_q[SqrtStages]), .angle_o(yaw_a)
  );

  // output stage: saturation, gimbal lock and zero-norm overrides
  function automatic logic [15:0] sat_angle(input qte_angle_t a,
                                            input logic [MagW-1:0] lim);
    logic [MagW-1:0] m;
    m = (a.mag > lim) ? lim : a.mag;
    return a.neg ? 16'(-m) : 16'(m);
  endfunction

  qte_side_t   sd;
  logic [15:0] roll_d, yaw_d, pitch_d;
  assign sd = side_q[SideLen];

  always_comb begin
    roll_d  = sat_angle(roll_a, PiQ13);
    yaw_d   = sat_angle(yaw_a, PiQ13);
    pitch_d = sat_angle(pitch_a, HalfPiQ13);
    if (sd.gimbal) begin
      pitch_d = sd.p_pos ? 16'(HalfPiQ13) : 16'(-HalfPiQ13);
    end
    if (sd.zero) begin
      roll_d  = '0;
      yaw_d   = '0;
      pitch_d = '0;
    end
  end

  logic [47:0] tdata_q;
  logic        zero_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= {1'b0, yaw_d, pitch_d[14:0], roll_d};
      zero_q  <= sd.zero;
    end
  end

  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = zero_q;

endmodule
`default_nettype wire

FILE: rtl/core/qte_checker.sv
`default_nettype none
module qte_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  logic signed [15:0] roll, yaw;
  logic signed [14:0] pitch;
  assign roll  = m_axis_tdata[15:0];
  assign pitch = m_axis_tdata[30:16];
  assign yaw   = m_axis_tdata[46:31];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled request changed");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("zero-norm request with nonzero angles");

  a_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pitch <= 15'sd12868 && pitch >= -15'sd12868)
    else $error("pitch out of range");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> roll <= 16'sd25736 && roll >= -16'sd25736
      && yaw <= 16'sd25736 && yaw >= -16'sd25736 && !m_axis_tdata[47])
    else $error("roll or yaw out of range");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);
`default_nettype wire
